// ===== hw/rtl/bpc_pkg.sv =====
// Package for the boot path checker: sizes, character codes and the
// input stage record. No dependencies.
package bpc_pkg;

  localparam int PATH_LIMIT = 256;
  localparam int CNT_W      = $clog2(PATH_LIMIT + 1);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [31:0] DEV_SD     = 32'h0000_7364;
  localparam logic [31:0] DEV_CD     = 32'h0000_6364;
  localparam logic [31:0] DEV_PC     = 32'h0000_7063;
  localparam logic [31:0] DEV_IDE    = 32'h0069_6465;
  localparam logic [31:0] DEV_BRD    = 32'h0062_7264;
  localparam logic [31:0] SUFFIX_BIN = 32'h2E62_696E;

  localparam logic [2:0] DEV_MAX_LEN = 3'd4;
  localparam int         MIN_LEN     = 4;

  // Registered input byte handed from the input stage to the scanner
  typedef struct packed {
    logic       valid;
    logic [7:0] path_byte;
    logic       final_byte;
  } stage_t;

endpackage

// ===== hw/rtl/bpc_in_if.sv =====
// Input channel of the boot path checker: one path byte per transfer.
// No dependencies.
interface bpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       final_byte;

  modport source (output valid, output path_byte, output final_byte, input ready);
  modport sink   (input valid, input path_byte, input final_byte, output ready);
endinterface

// ===== hw/rtl/bpc_out_if.sv =====
// Result channel of the boot path checker: one verdict per transfer.
// No dependencies.
interface bpc_out_if;
  logic valid;
  logic ready;
  logic path_ok;

  modport source (output valid, output path_ok, input ready);
  modport sink   (input valid, input path_ok, output ready);
endinterface

// ===== hw/rtl/boot_path_checker.sv =====
// Top level of the boot path checker: input register and path scanner.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if, bpc_in_stage and bpc_scan.
//
// Takes a boot path one byte per transfer and gives a single verdict transfer
// on the byte marked final: path_ok is 1 when the path starts with '/', names
// a known device (sd, ide, cd, pc or brd, optionally with a digit 0 to 3), has
// only non-empty components other than '.' and '..', holds no control byte,
// backslash or colon, has no trailing slash, is shorter than PATH_LIMIT bytes
// and ends in ".bin" in any case. One byte is taken every cycle unless a final
// byte waits on a stalled result, with no gaps between paths. Each byte is caught
// in an input register at its transfer edge, then passes through the rule logic
// into the rule state and, on a final byte, into the result register, from which
// the verdict is offered. The scanner returns to its idle state after every
// verdict. A stalled result only holds back input once a further final byte
// reaches the input register; ordinary bytes keep flowing meanwhile.
module boot_path_checker (
  input  logic      clk,
  input  logic      rst,
  bpc_in_if.sink    in_ch,
  bpc_out_if.source out_ch
);

  bpc_pkg::stage_t stage;
  logic            advance;

  // Input register: one byte, refilled in the cycle it moves on
  bpc_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  // Rule state, verdict logic and result register
  bpc_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

// ===== hw/rtl/bpc_in_stage.sv =====
// Input register of the boot path checker.
// Depends on bpc_pkg and bpc_in_if.
module bpc_in_stage (
  input  logic              clk,
  input  logic              rst,
  bpc_in_if.sink            in_ch,
  input  logic              advance,
  output bpc_pkg::stage_t   stage
);

  // Refill whenever the held byte leaves or there is none
  assign in_ch.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage.valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      stage.path_byte  <= in_ch.path_byte;
      stage.final_byte <= in_ch.final_byte;
    end
  end

endmodule

// ===== hw/rtl/bpc_scan.sv =====
// Path scanner of the boot path checker: rule state, verdict and result register.
// Depends on bpc_pkg and bpc_out_if.
module bpc_scan (
  input  logic              clk,
  input  logic              rst,
  input  bpc_pkg::stage_t   stage,
  output logic              advance,
  bpc_out_if.source         out_ch
);

  typedef enum logic [1:0] {PH_LEAD, PH_DEVICE, PH_COMP} phase_t;

  logic [bpc_pkg::CNT_W-1:0] byte_count, byte_count_next;
  phase_t                    phase, phase_next;
  logic [31:0]               device_chars, device_chars_next;
  logic [2:0]                device_length, device_length_next;
  logic [1:0]                segment_length, segment_length_next;
  logic                      segment_all_dots, segment_all_dots_next;
  logic [31:0]               tail_chars, tail_chars_next;
  logic                      failed, failed_next;
  logic                      seg_bad, verdict, take;
  logic [7:0]                b;

  function automatic logic dev_match(logic [31:0] chars, logic [2:0] len);
    logic [31:0] c;
    logic [2:0]  l;
    logic        m;
    c = chars;
    l = len;
    m = 1'b0;
    if (l != 3'd0 && l <= bpc_pkg::DEV_MAX_LEN) begin
      if (c[7:0] inside {[bpc_pkg::CH_ZERO:bpc_pkg::CH_THREE]}) begin
        c = c >> 8;
        l = l - 3'd1;
      end
      if (l == 3'd2) begin
        m = (c == bpc_pkg::DEV_SD) || (c == bpc_pkg::DEV_CD) || (c == bpc_pkg::DEV_PC);
      end else if (l == 3'd3) begin
        m = (c == bpc_pkg::DEV_IDE) || (c == bpc_pkg::DEV_BRD);
      end
    end
    return m;
  endfunction

  function automatic logic [31:0] fold_lower(logic [31:0] packed_chars);
    logic [31:0] r;
    logic [7:0]  c;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      c = packed_chars[8*i +: 8];
      if (c inside {[bpc_pkg::CH_UPA:bpc_pkg::CH_UPZ]}) c = c + bpc_pkg::CASE_OFS;
      r[8*i +: 8] = c;
    end
    return r;
  endfunction

  assign b       = stage.path_byte;
  assign advance = !out_ch.valid || out_ch.ready || !stage.final_byte;
  assign take    = stage.valid && advance;

  always_comb begin
    byte_count_next       = byte_count;
    if (byte_count < bpc_pkg::CNT_W'(bpc_pkg::PATH_LIMIT)) begin
      byte_count_next = byte_count + 1'b1;
    end
    tail_chars_next       = {tail_chars[23:0], b};
    phase_next            = phase;
    device_chars_next     = device_chars;
    device_length_next    = device_length;
    segment_length_next   = segment_length;
    segment_all_dots_next = segment_all_dots;
    failed_next           = failed;

    case (phase)
      PH_LEAD: begin
        if (b != bpc_pkg::CH_SLASH) failed_next = 1'b1;
        phase_next = PH_DEVICE;
      end
      PH_DEVICE: begin
        if (b == bpc_pkg::CH_SLASH) begin
          if (!dev_match(device_chars, device_length)) failed_next = 1'b1;
          phase_next            = PH_COMP;
          segment_length_next   = 2'd0;
          segment_all_dots_next = 1'b1;
        end else begin
          device_chars_next = {device_chars[23:0], b};
          if (device_length != 3'd7) device_length_next = device_length + 3'd1;
        end
      end
      PH_COMP: begin
        if (b == bpc_pkg::CH_SLASH) begin
          if (segment_length == 2'd0 || (segment_all_dots && segment_length <= 2'd2)) begin
            failed_next = 1'b1;
          end
          segment_length_next   = 2'd0;
          segment_all_dots_next = 1'b1;
        end else begin
          if (b < bpc_pkg::CH_SPACE || b == bpc_pkg::CH_BSL || b == bpc_pkg::CH_COLON) begin
            failed_next = 1'b1;
          end
          if (segment_length != 2'd3) segment_length_next = segment_length + 2'd1;
          if (b != bpc_pkg::CH_DOT) segment_all_dots_next = 1'b0;
        end
      end
      default: begin
        failed_next = 1'b1;
      end
    endcase

    seg_bad = (segment_length_next == 2'd0) ||
              (segment_all_dots_next && segment_length_next <= 2'd2);
    verdict = !failed_next && (phase_next == PH_COMP) && (b != bpc_pkg::CH_SLASH) &&
              !seg_bad &&
              (byte_count_next < bpc_pkg::CNT_W'(bpc_pkg::PATH_LIMIT)) &&
              (byte_count_next > bpc_pkg::CNT_W'(bpc_pkg::MIN_LEN)) &&
              (fold_lower(tail_chars_next) == bpc_pkg::SUFFIX_BIN);
  end

  always_ff @(posedge clk) begin
    if (rst || (take && stage.final_byte)) begin
      byte_count       <= '0;
      phase            <= PH_LEAD;
      device_chars     <= '0;
      device_length    <= '0;
      segment_length   <= '0;
      segment_all_dots <= 1'b1;
      tail_chars       <= '0;
      failed           <= 1'b0;
    end else if (take) begin
      byte_count       <= byte_count_next;
      phase            <= phase_next;
      device_chars     <= device_chars_next;
      device_length    <= device_length_next;
      segment_length   <= segment_length_next;
      segment_all_dots <= segment_all_dots_next;
      tail_chars       <= tail_chars_next;
      failed           <= failed_next;
    end

    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (take && stage.final_byte) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (take && stage.final_byte) begin
      out_ch.path_ok <= verdict;
    end
  end

endmodule

// ===== hw/rtl/bpc_checker.sv =====
// Port-level checks for the boot path checker, bound to the top level.
// Depends on boot_path_checker.
module bpc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_final,
  input logic out_valid,
  input logic out_ready,
  input logic out_ok
);

  logic [1:0] pending;
  logic       in_fin_xfer, out_xfer;

  assign in_fin_xfer = in_valid && in_ready && in_final;
  assign out_xfer    = out_valid && out_ready;

  // Final bytes taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + {1'b0, in_fin_xfer} - {1'b0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ok))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> pending != 2'd0)
    else $error("result without a final byte");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("too many verdicts outstanding");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with result side idle");

endmodule

bind boot_path_checker bpc_checker u_bpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_final  (in_ch.final_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_ok    (out_ch.path_ok)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for boot_path_checker: drives path bytes, predicts
// each verdict and compares it with the result channel.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if and the boot_path_checker RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transfer on either channel before the run is abandoned.
  // A correct run never gets near this, since each side idles only about a
  // third of the time.
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_BYTES = 950;

  typedef logic [7:0] byte_q_t[$];

  // Scanner phases of the path rules. The fourth code is unused; if it were
  // ever reached the path would fail.
  typedef enum logic [1:0] {SCAN_LEAD, SCAN_DEVICE, SCAN_COMP} scan_phase_t;

  // Predicts the verdict of every path from its transfers and checks the
  // verdicts that come back, oldest first.
  class path_scoreboard;
    logic [bpc_pkg::CNT_W-1:0] path_len;
    scan_phase_t               phase;
    logic [31:0]               dev_chars;
    logic [2:0]                dev_len;
    logic [1:0]                seg_len;
    bit                        seg_dots;
    logic [31:0]               tail_chars;
    bit                        failed;
    bit                        verdict_q[$];
    int                        errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      path_len   = '0;
      phase      = SCAN_LEAD;
      dev_chars  = '0;
      dev_len    = '0;
      seg_len    = '0;
      seg_dots   = 1'b1;
      tail_chars = '0;
      failed     = 1'b0;
    endfunction

    // Device segment: sd, ide, cd, pc or brd, optionally with a digit 0..3
    function bit device_known();
      logic [31:0] chars;
      logic [2:0]  len;
      chars = dev_chars;
      len   = dev_len;
      if (len == 0 || len > bpc_pkg::DEV_MAX_LEN) return 1'b0;
      if (chars[7:0] >= bpc_pkg::CH_ZERO && chars[7:0] <= bpc_pkg::CH_THREE) begin
        chars = chars >> 8;
        len   = len - 3'd1;
      end
      if (len == 3'd2)
        return chars == bpc_pkg::DEV_SD || chars == bpc_pkg::DEV_CD ||
               chars == bpc_pkg::DEV_PC;
      if (len == 3'd3) return chars == bpc_pkg::DEV_IDE || chars == bpc_pkg::DEV_BRD;
      return 1'b0;
    endfunction

    // Empty, "." and ".." components are rejected
    function bit segment_bad();
      return seg_len == 2'd0 || (seg_dots && seg_len <= 2'd2);
    endfunction

    function logic [31:0] tail_lower();
      logic [31:0] folded;
      logic [7:0]  c;
      for (int k = 0; k < 4; k++) begin
        c = tail_chars[8*k +: 8];
        if (c >= bpc_pkg::CH_UPA && c <= bpc_pkg::CH_UPZ) c = c + bpc_pkg::CASE_OFS;
        folded[8*k +: 8] = c;
      end
      return folded;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      bit ok;
      if (path_len < bpc_pkg::PATH_LIMIT) path_len = path_len + 1'b1;
      tail_chars = {tail_chars[23:0], b};
      case (phase)
        SCAN_LEAD: begin
          if (b != bpc_pkg::CH_SLASH) failed = 1'b1;
          phase = SCAN_DEVICE;
        end
        SCAN_DEVICE: begin
          if (b == bpc_pkg::CH_SLASH) begin
            if (!device_known()) failed = 1'b1;
            phase    = SCAN_COMP;
            seg_len  = '0;
            seg_dots = 1'b1;
          end else begin
            dev_chars = {dev_chars[23:0], b};
            if (dev_len < 3'd7) dev_len = dev_len + 3'd1;
          end
        end
        SCAN_COMP: begin
          if (b == bpc_pkg::CH_SLASH) begin
            if (segment_bad()) failed = 1'b1;
            seg_len  = '0;
            seg_dots = 1'b1;
          end else begin
            if (b < bpc_pkg::CH_SPACE || b == bpc_pkg::CH_BSL || b == bpc_pkg::CH_COLON)
              failed = 1'b1;
            if (seg_len < 2'd3) seg_len = seg_len + 2'd1;
            if (b != bpc_pkg::CH_DOT) seg_dots = 1'b0;
          end
        end
        default: failed = 1'b1;
      endcase
      if (fin) begin
        ok = !failed;
        if (phase != SCAN_COMP || b == bpc_pkg::CH_SLASH || segment_bad()) ok = 1'b0;
        if (path_len >= bpc_pkg::PATH_LIMIT || path_len <= bpc_pkg::MIN_LEN) ok = 1'b0;
        if (tail_lower() != bpc_pkg::SUFFIX_BIN) ok = 1'b0;
        verdict_q.push_back(ok);
        restart();
      end
    endfunction

    function void check_verdict(logic ok);
      bit want;
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict transfer path_ok=%0b with no path pending", $time, ok);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (ok !== want) begin
          $display("%0t: path_ok expected %0b, actual %0b", $time, want, ok);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   in_idle_pct  = 34;
  int   out_idle_pct = 34;
  int   stall_cycles = 0;

  path_scoreboard board = new();

  bpc_in_if  in_ch();
  bpc_out_if out_ch();

  boot_path_checker DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: ready drops at random, except in the no-idle stretch
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Both channels are sampled at the edge; the predictor sees every input
  // transfer, and every result transfer is checked against it.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      board.note_byte(in_ch.path_byte, in_ch.final_byte);
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_verdict(out_ch.path_ok);
  end

  // Watchdog: any transfer restarts the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // One byte; valid stays high into the next call unless that call idles
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.path_byte  <= b;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_bytes(input byte_q_t p);
    foreach (p[i]) send_byte(p[i], i == p.size() - 1);
  endtask

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    return q;
  endfunction

  // "/sd/" + filler + ".bin", total bytes as given
  function automatic byte_q_t padded_path(int total);
    byte_q_t q;
    q = text_bytes("/sd/");
    repeat (total - 8) q.push_back(bpc_pkg::CH_UPA + bpc_pkg::CASE_OFS);
    q.push_back(bpc_pkg::CH_DOT);
    q.push_back(8'h62);
    q.push_back(8'h69);
    q.push_back(8'h6E);
    return q;
  endfunction

  // Mostly plain name bytes; dots and arbitrary bytes mixed in
  function automatic logic [7:0] comp_char();
    case ($urandom_range(19))
      0, 1:    return 8'($urandom_range(255));
      2, 3:    return bpc_pkg::CH_DOT;
      4:       return bpc_pkg::CH_UPA + 8'($urandom_range(25));
      5:       return bpc_pkg::CH_ZERO + 8'($urandom_range(9));
      default: return bpc_pkg::CH_UPA + bpc_pkg::CASE_OFS + 8'($urandom_range(25));
    endcase
  endfunction

  // Mostly well-formed paths with random content, some broken on purpose,
  // a few of pure noise and now and then one near the length limit.
  function automatic byte_q_t random_path();
    byte_q_t    p;
    string      names[5] = '{"sd", "ide", "cd", "pc", "brd"};
    string      dev;
    string      suffix = ".bin";
    logic [7:0] ch;
    int         ncomp;
    if ($urandom_range(29) == 0) begin
      repeat ($urandom_range(1, 12)) p.push_back(8'($urandom_range(255)));
      return p;
    end
    p.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : bpc_pkg::CH_SLASH);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(0, 9)) p.push_back(comp_char());
    end else begin
      dev = names[$urandom_range(4)];
      foreach (dev[i]) p.push_back(dev[i]);
      if ($urandom_range(1)) p.push_back(bpc_pkg::CH_ZERO + 8'($urandom_range(9)));
    end
    ncomp = $urandom_range(1, 4);
    for (int c = 0; c < ncomp; c++) begin
      p.push_back(bpc_pkg::CH_SLASH);
      if ($urandom_range(49) == 0) begin
        repeat ($urandom_range(230, 260))
          p.push_back(bpc_pkg::CH_UPA + 8'($urandom_range(25)));
      end else begin
        case ($urandom_range(15))
          0:       ;
          1:       p.push_back(bpc_pkg::CH_DOT);
          2:       begin p.push_back(bpc_pkg::CH_DOT); p.push_back(bpc_pkg::CH_DOT); end
          default: repeat ($urandom_range(1, 8)) p.push_back(comp_char());
        endcase
      end
    end
    if ($urandom_range(7) != 0) begin
      foreach (suffix[k]) begin
        ch = suffix[k];
        if (ch != bpc_pkg::CH_DOT && $urandom_range(1)) ch = ch - bpc_pkg::CASE_OFS;
        p.push_back(ch);
      end
    end
    if ($urandom_range(19) == 0) p.push_back(bpc_pkg::CH_SLASH);
    // cut short: final byte lands anywhere, device segment included
    if ($urandom_range(9) == 0) begin
      ncomp = $urandom_range(1, p.size());
      while (p.size() > ncomp) void'(p.pop_back());
    end
    return p;
  endfunction

  initial begin
    byte_q_t bq;
    int      sent;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.path_byte  = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed paths: every device form, each rule broken at least once, extremes
    send_bytes(text_bytes("/sd/boot.bin"));
    send_bytes(text_bytes("/ide2/sys/KERNEL.BIN"));
    send_bytes(text_bytes("/cd3/x.Bin"));
    send_bytes(text_bytes("/pc0/.../a.bIn"));      // three dots is a real name
    send_bytes(text_bytes("/brd/a/b/c.bin"));
    send_bytes(text_bytes("/sd4/a.bin"));          // digit out of range
    send_bytes(text_bytes("/sdcard/a.bin"));       // device too long
    send_bytes(text_bytes("/abcdefghij/a.bin"));   // device length saturates
    send_bytes(text_bytes("//a.bin"));             // empty device
    send_bytes(text_bytes("/sd"));                 // ends in the device
    send_bytes(text_bytes("/sd/"));                // ends right after it
    bq = text_bytes("/s/a.bin");
    bq.insert(2, 8'h01);                           // control byte in device
    send_bytes(bq);
    send_bytes(text_bytes("/sd/./a.bin"));
    send_bytes(text_bytes("/sd/../a.bin"));
    send_bytes(text_bytes("/sd//a.bin"));
    send_bytes(text_bytes("/sd/a\\b.bin"));
    send_bytes(text_bytes("/sd/c:a.bin"));
    bq = text_bytes("/sd/a.bin");
    bq.insert(5, 8'h00);                           // zero byte
    send_bytes(bq);
    bq = text_bytes("/pc1/.bin");
    bq.insert(5, 8'hFF);                           // top byte value is legal
    send_bytes(bq);
    send_bytes(text_bytes("/sd/a.bin/"));          // trailing slash
    send_bytes(text_bytes("sd/a.bin"));            // no leading slash
    send_bytes(text_bytes("/"));
    send_bytes(text_bytes("/sd/a.bim"));
    send_bytes(padded_path(bpc_pkg::PATH_LIMIT - 1));   // longest that passes
    send_bytes(padded_path(bpc_pkg::PATH_LIMIT));
    send_bytes(padded_path(bpc_pkg::PATH_LIMIT + 44));  // count saturates

    // Random paths, with a stretch of back-to-back transfers on both sides
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      in_idle_pct  = (sent >= 300 && sent < 700) ? 0 : 34;
      out_idle_pct = in_idle_pct;
      bq = random_path();
      sent += bq.size();
      send_bytes(bq);
    end
    in_ch.valid <= 1'b0;

    // Drain: all verdicts back, then a short wait for any stray transfer
    while (board.verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.verdict_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
